// ===== hw/rtl/cfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

	typedef logic [2:0] kind_t;

	localparam kind_t KIND_PAYLOAD  = 3'd0;
	localparam kind_t KIND_GOOD     = 3'd1;
	localparam kind_t KIND_DATA_BAD = 3'd2;
	localparam kind_t KIND_HDR_BAD  = 3'd3;
	localparam kind_t KIND_OVERSIZE = 3'd4;

	typedef logic cfg_index_t;

	localparam cfg_index_t CFG_START_MARKER = 1'b0;
	localparam cfg_index_t CFG_MAX_PAYLOAD  = 1'b1;

	localparam logic [7:0]  START_MARKER_RESET = 8'd165;
	localparam logic [15:0] MAX_PAYLOAD_RESET  = 16'd512;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  frame_type;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [15:0] frame_length;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cfp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfp_front
	import cfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire cfg_index_t  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             push,
	output result_t          push_data
);

	localparam logic [2:0] PH_HUNT     = 3'd0;
	localparam logic [2:0] PH_TYPE     = 3'd1;
	localparam logic [2:0] PH_LEN_LO   = 3'd2;
	localparam logic [2:0] PH_LEN_HI   = 3'd3;
	localparam logic [2:0] PH_HDR_SUM  = 3'd4;
	localparam logic [2:0] PH_BODY     = 3'd5;
	localparam logic [2:0] PH_DATA_SUM = 3'd6;

	logic [7:0]  start_marker_q;
	logic [15:0] max_payload_q;

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  len_lo_q, len_lo_d;
	logic [15:0] decl_q, decl_d;
	logic [15:0] seen_q, seen_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  hsum;
	logic        emit;
	kind_t       emit_kind;
	logic        accept;

	assign accept = in_valid && in_ready;
	assign hsum = start_marker_q + type_q + len_lo_q + decl_q[15:8];

	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		len_lo_d  = len_lo_q;
		decl_d    = decl_q;
		seen_d    = seen_q;
		sum_d     = sum_q;
		emit      = 1'b0;
		emit_kind = KIND_PAYLOAD;
		unique case (phase_q)
			PH_TYPE: begin
				type_d  = rx_byte;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_lo_d = rx_byte;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				decl_d = {rx_byte, len_lo_q};
				if (decl_d > max_payload_q) begin
					phase_d   = PH_HUNT;
					emit      = 1'b1;
					emit_kind = KIND_OVERSIZE;
				end else begin
					seen_d  = '0;
					phase_d = PH_HDR_SUM;
				end
			end
			PH_HDR_SUM: begin
				if (hsum != rx_byte) begin
					phase_d   = PH_HUNT;
					emit      = 1'b1;
					emit_kind = KIND_HDR_BAD;
				end else begin
					sum_d   = {hsum[6:0], 1'b0};
					phase_d = (decl_q != '0) ? PH_BODY : PH_DATA_SUM;
				end
			end
			PH_BODY: begin
				sum_d     = sum_q + rx_byte;
				seen_d    = seen_q + 16'd1;
				phase_d   = (seen_d == decl_q) ? PH_DATA_SUM : PH_BODY;
				emit      = 1'b1;
				emit_kind = KIND_PAYLOAD;
			end
			PH_DATA_SUM: begin
				phase_d   = PH_HUNT;
				emit      = 1'b1;
				emit_kind = (sum_q == rx_byte) ? KIND_GOOD : KIND_DATA_BAD;
			end
			default: begin
				phase_d = (rx_byte == start_marker_q) ? PH_TYPE : PH_HUNT;
			end
		endcase
	end

	assign push = accept && emit;

	always_comb begin
		push_data.kind         = emit_kind;
		push_data.frame_type   = type_q;
		push_data.data_byte    = rx_byte;
		push_data.byte_index   = seen_q;
		push_data.frame_length = decl_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RESET;
			max_payload_q  <= MAX_PAYLOAD_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_START_MARKER: start_marker_q <= cfg_data[7:0];
				CFG_MAX_PAYLOAD:  max_payload_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			type_q   <= '0;
			len_lo_q <= '0;
			decl_q   <= '0;
			seen_q   <= '0;
			sum_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			len_lo_q <= len_lo_d;
			decl_q   <= decl_d;
			seen_q   <= seen_d;
			sum_q    <= sum_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cfp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfp_queue
	import cfp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         full,
	input  wire logic    pop,
	output logic         not_empty,
	output result_t      pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	result_t       entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == FULL_COUNT);
	assign not_empty = (count_q != '0);
	assign pop_data  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("queue count exceeds depth");

	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("transfer into a full queue");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("transfer out of an empty queue");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a push");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/cfp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfp_back
	import cfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_not_empty,
	input  wire result_t     q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [7:0]       frame_type,
	output logic [7:0]       data_byte,
	output logic [15:0]      byte_index,
	output logic [15:0]      frame_length
);

	logic    valid_q;
	result_t res_q;
	logic    is_payload;

	assign q_pop      = q_not_empty && (!valid_q || out_ready);
	assign is_payload = (q_data.kind == KIND_PAYLOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q.kind         <= q_data.kind;
			res_q.frame_type   <= q_data.frame_type;
			res_q.data_byte    <= is_payload ? q_data.data_byte : 8'd0;
			res_q.byte_index   <= is_payload ? q_data.byte_index : 16'd0;
			res_q.frame_length <= q_data.frame_length;
		end
	end

	assign out_valid    = valid_q;
	assign kind         = res_q.kind;
	assign frame_type   = res_q.frame_type;
	assign data_byte    = res_q.data_byte;
	assign byte_index   = res_q.byte_index;
	assign frame_length = res_q.frame_length;

endmodule

`default_nettype wire

// ===== hw/rtl/checksummed_frame_parser.sv =====
// Channel   Handshake              Payload
// cfg       cfg_valid, cfg_ready   cfg_index (0 start marker, 1 max payload), cfg_data
// in        in_valid, in_ready     rx_byte
// out       out_valid, out_ready   kind, frame_type, data_byte, byte_index, frame_length
//
// The parser takes one byte every cycle while in_ready is high; the phase register in the
// front stage is updated in the same cycle as the transfer.
// A result is written into the result queue at its byte's transfer and is then loaded into
// the output register, from which it leaves the block.
// In-ready drops only while the result queue is full, so an output stall reaches the input
// after QUEUE_DEPTH + 1 held results.
// Reset loads the register defaults, empties the queue and puts the parser in hunt.
`timescale 1ns / 1ps
`default_nettype none

module checksummed_frame_parser
	import cfp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire cfg_index_t  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [7:0]       frame_type,
	output logic [7:0]       data_byte,
	output logic [15:0]      byte_index,
	output logic [15:0]      frame_length
);

	logic    push;
	result_t push_data;
	logic    q_full;
	logic    q_pop;
	logic    q_not_empty;
	result_t q_data;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;

	cfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.push      (push),
		.push_data (push_data)
	);

	cfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_data)
	);

	cfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.frame_type   (frame_type),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.frame_length (frame_length)
	);

endmodule

`default_nettype wire

// ===== dv/checksummed_frame_parser_test.sv =====
`timescale 1ns / 1ps

module checksummed_frame_parser_test;
	import cfp_pkg::*;

	localparam int DRAIN_CYCLES = 12;

	typedef enum logic [2:0] {
		P_HUNT, P_TYPE, P_LEN_LO, P_LEN_HI, P_HSUM, P_BODY, P_DSUM
	} parse_phase_t;

	class parser_scoreboard;
		logic [7:0]   marker;
		logic [15:0]  max_len;
		parse_phase_t phase;
		logic [7:0]   type_q;
		logic [7:0]   len_lo_q;
		logic [15:0]  length_q;
		logic [15:0]  count_q;
		logic [7:0]   sum_q;
		result_t      due_results[$];
		int           errors;

		function new();
			marker = START_MARKER_RESET;
			max_len = MAX_PAYLOAD_RESET;
			phase = P_HUNT;
			type_q = '0;
			len_lo_q = '0;
			length_q = '0;
			count_q = '0;
			sum_q = '0;
			errors = 0;
		endfunction

		function void set_register(cfg_index_t idx, logic [15:0] data);
			if (idx == CFG_START_MARKER) begin
				marker = data[7:0];
			end else begin
				max_len = data;
			end
		endfunction

		function void push_result(kind_t k, logic [7:0] d, logic [15:0] idx);
			result_t r;
			r.kind = k;
			r.frame_type = type_q;
			r.data_byte = d;
			r.byte_index = idx;
			r.frame_length = length_q;
			due_results.push_back(r);
		endfunction

		function void take_byte(logic [7:0] b);
			logic [7:0] hsum;
			hsum = marker + type_q + len_lo_q + length_q[15:8];
			case (phase)
				P_TYPE: begin
					type_q = b;
					phase = P_LEN_LO;
				end
				P_LEN_LO: begin
					len_lo_q = b;
					phase = P_LEN_HI;
				end
				P_LEN_HI: begin
					length_q = {b, len_lo_q};
					if (length_q > max_len) begin
						phase = P_HUNT;
						push_result(KIND_OVERSIZE, 8'd0, 16'd0);
					end else begin
						count_q = '0;
						phase = P_HSUM;
					end
				end
				P_HSUM: begin
					if (hsum != b) begin
						phase = P_HUNT;
						push_result(KIND_HDR_BAD, 8'd0, 16'd0);
					end else begin
						sum_q = hsum + hsum;
						phase = (length_q != 16'd0) ? P_BODY : P_DSUM;
					end
				end
				P_BODY: begin
					sum_q = sum_q + b;
					push_result(KIND_PAYLOAD, b, count_q);
					count_q = count_q + 16'd1;
					if (count_q == length_q) begin
						phase = P_DSUM;
					end
				end
				P_DSUM: begin
					phase = P_HUNT;
					push_result((sum_q == b) ? KIND_GOOD : KIND_DATA_BAD, 8'd0, 16'd0);
				end
				default: begin
					phase = (b == marker) ? P_TYPE : P_HUNT;
				end
			endcase
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		task report(string msg);
			errors++;
			$display("%0t mismatch: %s", $time, msg);
		endtask

		task check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				report($sformatf("result kind %0d with nothing outstanding", got.kind));
				return;
			end
			want = due_results.pop_front();
			if (got.kind != want.kind) begin
				report($sformatf("kind %0d, want %0d", got.kind, want.kind));
			end
			if (got.frame_type != want.frame_type) begin
				report($sformatf("frame_type %0h, want %0h", got.frame_type,
					want.frame_type));
			end
			if (got.data_byte != want.data_byte) begin
				report($sformatf("data_byte %0h, want %0h", got.data_byte, want.data_byte));
			end
			if (got.byte_index != want.byte_index) begin
				report($sformatf("byte_index %0d, want %0d", got.byte_index,
					want.byte_index));
			end
			if (got.frame_length != want.frame_length) begin
				report($sformatf("frame_length %0d, want %0d", got.frame_length,
					want.frame_length));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_index_t  cfg_index = CFG_START_MARKER;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  frame_type;
	logic [7:0]  data_byte;
	logic [15:0] byte_index;
	logic [15:0] frame_length;

	parser_scoreboard sb;
	bit calm = 1'b0;
	int n_sent = 0;

	checksummed_frame_parser u_top (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		forever begin
			out_ready <= 1'b1;
			if (calm) begin
				@(posedge clk);
			end else begin
				repeat ($urandom_range(1, 30)) @(posedge clk);
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result({kind, frame_type, data_byte, byte_index, frame_length});
		end
	end

	task automatic send_byte(logic [7:0] b);
		if (!calm && $urandom_range(0, 11) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.take_byte(b);
		n_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] data);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// A negative cut sends the whole frame; otherwise only its first cut bytes go out.
	task automatic send_frame(logic [7:0] ptype, logic [15:0] len, bit hsum_ok, bit dsum_ok,
			int cut);
		logic [7:0] hsum;
		logic [7:0] dsum;
		logic [7:0] b;
		logic [7:0] frame_q[$];
		hsum = sb.marker + ptype + len[7:0] + len[15:8];
		dsum = hsum + hsum;
		frame_q.push_back(sb.marker);
		frame_q.push_back(ptype);
		frame_q.push_back(len[7:0]);
		frame_q.push_back(len[15:8]);
		if (len <= sb.max_len) begin
			frame_q.push_back(hsum_ok ? hsum : hsum ^ 8'($urandom_range(1, 255)));
			if (hsum_ok) begin
				for (int i = 0; i < len; i++) begin
					b = 8'($urandom_range(0, 255));
					dsum = dsum + b;
					frame_q.push_back(b);
				end
				frame_q.push_back(dsum_ok ? dsum : dsum ^ 8'($urandom_range(1, 255)));
			end
		end
		foreach (frame_q[i]) begin
			if (cut < 0 || i < cut) begin
				send_byte(frame_q[i]);
			end
		end
	endtask

	task automatic random_frame();
		logic [15:0] len;
		int pick;
		int cut;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			return;
		end
		cut = (pick < 14) ? $urandom_range(1, 6) : -1;
		if (pick >= 94 && sb.max_len != 16'hFFFF) begin
			len = 16'($urandom_range(sb.max_len + 1, 16'hFFFF));
		end else begin
			len = ($urandom_range(0, 99) < 90) ? 16'($urandom_range(0, 12))
				: 16'($urandom_range(0, 300));
			if (len > sb.max_len) begin
				len = sb.max_len;
			end
		end
		send_frame(8'($urandom_range(0, 255)), len, $urandom_range(0, 9) != 0,
			$urandom_range(0, 5) != 0, cut);
	endtask

	task automatic run_phase(logic [7:0] marker, logic [15:0] max_len, int n_bytes);
		int stop_at;
		write_reg(CFG_START_MARKER, {8'($urandom_range(0, 255)), marker});
		write_reg(CFG_MAX_PAYLOAD, max_len);
		stop_at = n_sent + n_bytes;
		while (n_sent < stop_at - n_bytes / 2) random_frame();
		settle();
		while (n_sent < stop_at) random_frame();
	endtask

	task automatic directed();
		send_byte(8'h00);
		send_frame(8'hFF, 16'd2, 1'b1, 1'b1, -1);
		send_frame(8'h00, 16'd0, 1'b1, 1'b0, -1);
		// A failing header sum equal to the marker must not open a new frame.
		send_byte(START_MARKER_RESET);
		send_byte(8'h5A);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(START_MARKER_RESET);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_frame(8'h11, 16'hFFFF, 1'b1, 1'b1, -1);
		// The length limit is read on the length high byte.
		send_byte(START_MARKER_RESET);
		send_byte(8'h22);
		send_byte(8'h01);
		write_reg(CFG_MAX_PAYLOAD, 16'd0);
		send_byte(8'h00);
		write_reg(CFG_MAX_PAYLOAD, MAX_PAYLOAD_RESET);
		// The header sum uses the marker in force when the sum byte arrives.
		send_byte(START_MARKER_RESET);
		send_byte(8'h33);
		send_byte(8'h00);
		send_byte(8'h00);
		write_reg(CFG_START_MARKER, 16'h0010);
		send_byte(8'h43);
		send_byte(8'h86);
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		directed();
		run_phase(8'h00, 16'h0000, 230);
		run_phase(8'hFF, 16'hFFFF, 330);
		run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(1, 40)), 330);
		write_reg(CFG_START_MARKER, {8'h00, START_MARKER_RESET});
		calm = 1'b1;
		run_phase(START_MARKER_RESET, MAX_PAYLOAD_RESET, 280);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() == 0 && sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== checksummed_frame_parser.f =====
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_front.sv
hw/rtl/cfp_queue.sv
hw/rtl/cfp_back.sv
hw/rtl/checksummed_frame_parser.sv
dv/checksummed_frame_parser_test.sv
